// ----- hdl/mea_pkg.sv -----
// ----------------------------------------------------------------------------
// mea_pkg
// shared types, constants and table functions for the entropy accumulator
// ----------------------------------------------------------------------------
package mea_pkg;

   localparam int MAX_ELEMENTS = 32;
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int STEP_W       = 6;
   localparam int LOG_STEPS    = 16;
   localparam int DIV_W        = 48;

   localparam logic [16:0] ONE_Q16      = 17'h10000;
   localparam logic [20:0] SIXTEEN_Q16  = 21'h100000;
   localparam logic [31:0] LN2_Q30      = 32'd744261118;
   localparam logic [20:0] U21_MAX      = 21'h1FFFFF;
   localparam logic [20:0] RENYI_NEG1   = 21'h1F0000;
   localparam logic [15:0] ORDER_Q_RST  = 16'h8000;
   localparam logic [15:0] SKIP_RST     = 16'h0001;

   localparam logic CSR_ORDER_Q = 1'b0;
   localparam logic CSR_SKIP    = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CHECK,
      OP_NORM_STEP,
      OP_LOG_START,
      OP_LOG_STEP,
      OP_SHAN,
      OP_LIN,
      OP_EXP_INIT,
      OP_EXP_STEP,
      OP_POW_ADD,
      OP_FLOG_INIT,
      OP_REN_NEG,
      OP_LNM,
      OP_DIV_INIT_R,
      OP_DIV_STEP,
      OP_REN_SAT,
      OP_DIV_INIT_T,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic keep_nz;
      logic last;
      logic norm_done;
      logic pow_small;
      logic out_busy;
   } status_type;

   typedef logic [LOG_STEPS-1:0][30:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bit_v;
      x     = x_in;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bit_v) begin
            x   = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^-(2^-k) in q30 for k = 1..16
   function automatic root_tab_type exp_roots();
      root_tab_type tab;
      logic [63:0]  r;
      r = 64'd1 << 29;
      for (int k = 0; k < LOG_STEPS; k++) begin
         r      = isqrt64(r << 30);
         tab[k] = r[30:0];
      end
      return tab;
   endfunction

   localparam root_tab_type EXP_ROOT = exp_roots();

endpackage

// ----- hdl/mea_ctrl.sv -----
// ----------------------------------------------------------------------------
// mea_ctrl
// sequencer: walks the datapath through log, terms, exp and final divides
// ----------------------------------------------------------------------------
module mea_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mea_pkg::status_type status,
   output mea_pkg::cmd_type    cmd
);
   import mea_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE  = 18'h00001,
      ST_CHECK = 18'h00002,
      ST_NORM  = 18'h00004,
      ST_LOG   = 18'h00008,
      ST_SHAN  = 18'h00010,
      ST_LIN   = 18'h00020,
      ST_EXPE  = 18'h00040,
      ST_EXP   = 18'h00080,
      ST_PADD  = 18'h00100,
      ST_TAIL  = 18'h00200,
      ST_FCHK  = 18'h00400,
      ST_LNM   = 18'h00800,
      ST_RDIVI = 18'h01000,
      ST_RDIV  = 18'h02000,
      ST_RSAT  = 18'h04000,
      ST_TDIVI = 18'h08000,
      ST_TDIV  = 18'h10000,
      ST_OUT   = 18'h20000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              fin_ff, fin_in;
   logic              log_end, div_end;

   assign log_end   = (step_ff == STEP_W'(LOG_STEPS - 1));
   assign div_end   = (step_ff == STEP_W'(DIV_W - 1));
   assign req_stall = (state_ff != ST_IDLE);
   assign cmd.step  = step_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      fin_in   = fin_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.op   = OP_CHECK;
            state_in = status.keep_nz ? ST_NORM : ST_TAIL;
         end
         ST_NORM: begin
            step_in = '0;
            if (status.norm_done) begin
               cmd.op   = OP_LOG_START;
               state_in = ST_LOG;
            end else begin
               cmd.op = OP_NORM_STEP;
            end
         end
         ST_LOG: begin
            cmd.op  = OP_LOG_STEP;
            step_in = step_ff + 1'b1;
            if (log_end) begin
               state_in = fin_ff ? ST_LNM : ST_SHAN;
            end
         end
         ST_SHAN: begin
            cmd.op   = OP_SHAN;
            state_in = ST_LIN;
         end
         ST_LIN: begin
            cmd.op   = OP_LIN;
            state_in = ST_EXPE;
         end
         ST_EXPE: begin
            cmd.op   = OP_EXP_INIT;
            step_in  = '0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            cmd.op  = OP_EXP_STEP;
            step_in = step_ff + 1'b1;
            if (log_end) begin
               state_in = ST_PADD;
            end
         end
         ST_PADD: begin
            cmd.op   = OP_POW_ADD;
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            state_in = status.last ? ST_FCHK : ST_IDLE;
         end
         ST_FCHK: begin
            if (status.pow_small) begin
               cmd.op   = OP_REN_NEG;
               state_in = ST_TDIVI;
            end else begin
               cmd.op   = OP_FLOG_INIT;
               fin_in   = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_LNM: begin
            cmd.op   = OP_LNM;
            state_in = ST_RDIVI;
         end
         ST_RDIVI: begin
            cmd.op   = OP_DIV_INIT_R;
            step_in  = '0;
            state_in = ST_RDIV;
         end
         ST_RDIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (div_end) begin
               state_in = ST_RSAT;
            end
         end
         ST_RSAT: begin
            cmd.op   = OP_REN_SAT;
            state_in = ST_TDIVI;
         end
         ST_TDIVI: begin
            cmd.op   = OP_DIV_INIT_T;
            step_in  = '0;
            state_in = ST_TDIV;
         end
         ST_TDIV: begin
            cmd.op  = OP_DIV_STEP;
            step_in = step_ff + 1'b1;
            if (div_end) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               fin_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

// ----- hdl/mea_dp.sv -----
// ----------------------------------------------------------------------------
// mea_dp
// datapath: shared multiplier, log/exp iteration registers, divider, sums
// ----------------------------------------------------------------------------
module mea_dp (
   input  logic                clock,
   input  logic                reset,
   input  mea_pkg::cmd_type    cmd,
   output mea_pkg::status_type status,
   input  logic [16:0]         req_probability,
   input  logic                req_last_element,
   input  logic                csr_valid,
   input  logic                csr_index,
   input  logic [15:0]         csr_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [20:0]         rsp_shannon_bits,
   output logic [20:0]         rsp_linear_entropy,
   output logic signed [20:0]  rsp_renyi_entropy,
   output logic signed [31:0]  rsp_tsallis_entropy
);
   import mea_pkg::*;

   logic [15:0]      order_q_ff, order_q_in;
   logic [15:0]      skip_ff, skip_in;
   logic [16:0]      p_ff, p_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      shannon_ff, shannon_in;
   logic [23:0]      linear_ff, linear_in;
   logic [31:0]      power_ff, power_in;
   logic [31:0]      z_ff, z_in;
   logic [4:0]       m_ff, m_in;
   logic [30:0]      y_ff, y_in;
   logic [15:0]      frac_ff, frac_in;
   logic [19:0]      e_ff, e_in;
   logic [30:0]      acc_ff, acc_in;
   logic [20:0]      lnm_ff, lnm_in;
   logic             neg_ff, neg_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [16:0]      rem_ff, rem_in;
   logic [20:0]      renyi_ff, renyi_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [20:0]      out_sh_ff, out_sh_in;
   logic [20:0]      out_lin_ff, out_lin_in;
   logic [20:0]      out_ren_ff, out_ren_in;
   logic [31:0]      out_ts_ff, out_ts_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [20:0] log_val, d_val, mag_val;
   logic        log_neg;
   logic [31:0] sq;
   logic [16:0] den;
   logic [17:0] r2;
   logic        ge;
   logic        keep;
   logic [4:0]  pow_sh;
   logic [31:0] ts_mag;
   logic        ts_neg;
   logic        emit;

   assign log_val = {m_ff, frac_ff};
   assign d_val   = SIXTEEN_Q16 - log_val;
   assign log_neg = (log_val < SIXTEEN_Q16);
   assign mag_val = log_neg ? (SIXTEEN_Q16 - log_val) : (log_val - SIXTEEN_Q16);
   assign keep    = (count_ff < CNT_W'(MAX_ELEMENTS)) && (p_ff >= {1'b0, skip_ff});
   assign sq      = prod[61:30];
   assign den     = ONE_Q16 - {1'b0, order_q_ff};
   assign r2      = {rem_ff, dq_ff[DIV_W-1]};
   assign ge      = (r2 >= {1'b0, den});
   assign pow_sh  = 5'd14 + {1'b0, e_ff[19:16]};
   assign ts_neg  = (power_ff < 32'(ONE_Q16));
   assign ts_mag  = ts_neg ? (32'(ONE_Q16) - power_ff) : (power_ff - 32'(ONE_Q16));
   assign emit    = (cmd.op == OP_EMIT);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_LOG_STEP: begin
            mul_a = {1'b0, y_ff};
            mul_b = {1'b0, y_ff};
         end
         OP_SHAN: begin
            mul_a = 32'(p_ff);
            mul_b = 32'(d_val);
         end
         OP_LIN: begin
            mul_a = 32'(p_ff);
            mul_b = 32'(ONE_Q16 - p_ff);
         end
         OP_EXP_INIT: begin
            mul_a = 32'(order_q_ff);
            mul_b = 32'(d_val);
         end
         OP_EXP_STEP: begin
            mul_a = {1'b0, acc_ff};
            mul_b = {1'b0, EXP_ROOT[cmd.step[3:0]]};
         end
         OP_LNM: begin
            mul_a = 32'(mag_val);
            mul_b = LN2_Q30;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      order_q_in = order_q_ff;
      skip_in    = skip_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORDER_Q: order_q_in = csr_data;
            CSR_SKIP:    skip_in    = csr_data;
            default:     order_q_in = order_q_ff;
         endcase
      end
   end

   always_comb begin
      p_in       = p_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      shannon_in = shannon_ff;
      linear_in  = linear_ff;
      power_in   = power_ff;
      z_in       = z_ff;
      m_in       = m_ff;
      y_in       = y_ff;
      frac_in    = frac_ff;
      e_in       = e_ff;
      acc_in     = acc_ff;
      lnm_in     = lnm_ff;
      neg_in     = neg_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      renyi_in   = renyi_ff;
      out_sh_in  = out_sh_ff;
      out_lin_in = out_lin_ff;
      out_ren_in = out_ren_ff;
      out_ts_in  = out_ts_ff;
      case (cmd.op)
         OP_LOAD: begin
            p_in    = (req_probability > ONE_Q16) ? ONE_Q16 : req_probability;
            last_in = req_last_element;
         end
         OP_CHECK: begin
            if (count_ff < CNT_W'(MAX_ELEMENTS)) begin
               count_in = count_ff + 1'b1;
            end
            if (keep && (p_ff == '0) && (order_q_ff == '0)) begin
               power_in = power_ff + 32'(ONE_Q16);
            end
            z_in = {p_ff, 15'd0};
            m_in = 5'd16;
         end
         OP_FLOG_INIT: begin
            z_in = power_ff;
            m_in = 5'd31;
         end
         OP_NORM_STEP: begin
            if (z_ff[31:24] == '0) begin
               z_in = z_ff << 8;
               m_in = m_ff - 5'd8;
            end else if (z_ff[31:28] == '0) begin
               z_in = z_ff << 4;
               m_in = m_ff - 5'd4;
            end else begin
               z_in = z_ff << 1;
               m_in = m_ff - 5'd1;
            end
         end
         OP_LOG_START: begin
            y_in    = z_ff[31:1];
            frac_in = '0;
         end
         OP_LOG_STEP: begin
            if (sq[31]) begin
               y_in = sq[31:1];
               frac_in[4'd15 - cmd.step[3:0]] = 1'b1;
            end else begin
               y_in = sq[30:0];
            end
         end
         OP_SHAN: begin
            shannon_in = shannon_ff + prod[47:16];
         end
         OP_LIN: begin
            linear_in = linear_ff + prod[39:16];
         end
         OP_EXP_INIT: begin
            e_in   = prod[35:16];
            acc_in = 31'h4000_0000;
         end
         OP_EXP_STEP: begin
            if (e_ff[4'd15 - cmd.step[3:0]]) begin
               acc_in = prod[60:30];
            end
         end
         OP_POW_ADD: begin
            power_in = power_ff + 32'(acc_ff >> pow_sh);
         end
         OP_REN_NEG: begin
            renyi_in = RENYI_NEG1;
         end
         OP_LNM: begin
            lnm_in = prod[50:30];
            neg_in = log_neg;
         end
         OP_DIV_INIT_R: begin
            dq_in  = {11'd0, lnm_ff, 16'd0};
            rem_in = '0;
         end
         OP_DIV_INIT_T: begin
            dq_in  = {ts_mag, 16'd0};
            rem_in = '0;
            neg_in = ts_neg;
         end
         OP_DIV_STEP: begin
            rem_in = ge ? 17'(r2 - {1'b0, den}) : r2[16:0];
            dq_in  = {dq_ff[DIV_W-2:0], ge};
         end
         OP_REN_SAT: begin
            if (!neg_ff) begin
               renyi_in = (dq_ff > DIV_W'(1048575)) ? 21'h0FFFFF : dq_ff[20:0];
            end else begin
               renyi_in = (dq_ff > DIV_W'(1048576)) ? 21'h100000 : (21'd0 - dq_ff[20:0]);
            end
         end
         OP_EMIT: begin
            out_sh_in  = (shannon_ff > 32'(U21_MAX)) ? U21_MAX : shannon_ff[20:0];
            out_lin_in = (linear_ff > 24'(U21_MAX)) ? U21_MAX : linear_ff[20:0];
            out_ren_in = renyi_ff;
            if (!neg_ff) begin
               out_ts_in = (dq_ff > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : dq_ff[31:0];
            end else begin
               out_ts_in = (dq_ff > DIV_W'(32'h8000_0000)) ? 32'h8000_0000
                                                         : (32'd0 - dq_ff[31:0]);
            end
            shannon_in = '0;
            linear_in  = '0;
            power_in   = '0;
            count_in   = '0;
         end
         default: begin
            p_in = p_ff;
         end
      endcase
   end

   assign rsp_valid_in = emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_q_ff   <= ORDER_Q_RST;
         skip_ff      <= SKIP_RST;
         count_ff     <= '0;
         shannon_ff   <= '0;
         linear_ff    <= '0;
         power_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         order_q_ff   <= order_q_in;
         skip_ff      <= skip_in;
         count_ff     <= count_in;
         shannon_ff   <= shannon_in;
         linear_ff    <= linear_in;
         power_ff     <= power_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      last_ff    <= last_in;
      z_ff       <= z_in;
      m_ff       <= m_in;
      y_ff       <= y_in;
      frac_ff    <= frac_in;
      e_ff       <= e_in;
      acc_ff     <= acc_in;
      lnm_ff     <= lnm_in;
      neg_ff     <= neg_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      renyi_ff   <= renyi_in;
      out_sh_ff  <= out_sh_in;
      out_lin_ff <= out_lin_in;
      out_ren_ff <= out_ren_in;
      out_ts_ff  <= out_ts_in;
   end

   assign status.keep_nz   = keep && (p_ff != '0);
   assign status.last      = last_ff;
   assign status.norm_done = z_ff[31];
   assign status.pow_small = (power_ff <= 32'(skip_ff));
   assign status.out_busy  = rsp_valid_ff & rsp_stall;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_shannon_bits    = out_sh_ff;
   assign rsp_linear_entropy  = out_lin_ff;
   assign rsp_renyi_entropy   = out_ren_ff;
   assign rsp_tsallis_entropy = out_ts_ff;

endmodule

// ----- hdl/multi_entropy_accumulator_unit.sv -----
// ----------------------------------------------------------------------------
// multi_entropy_accumulator_unit
// shannon, linear, renyi and tsallis entropy over vectors of probabilities
//
//   channel  direction  handshake           payload
//   req      in         req_valid/stall     probability, last_element
//   rsp      out        rsp_valid/stall     shannon, linear, renyi, tsallis
//   csr      in         csr_valid/ready     index, data
//
// a kept probability runs normalize, 16 log squaring rounds and 16 exp factor
// rounds on the one shared multiplier; a skipped probability only passes load,
// check and tail; a last beat adds a 48-step restoring divide for tsallis and,
// if the power sum exceeds skip, its log and a second such divide for renyi.
// reset is synchronous; the result register holds one beat, so a stalled
// result holds the next vector end in its output step with the input stalled
// ----------------------------------------------------------------------------
module multi_entropy_accumulator_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [16:0]        req_probability,
   input  logic               req_last_element,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [20:0]        rsp_shannon_bits,
   output logic [20:0]        rsp_linear_entropy,
   output logic signed [20:0] rsp_renyi_entropy,
   output logic signed [31:0] rsp_tsallis_entropy,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);
   import mea_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mea_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_probability     (req_probability),
      .req_last_element    (req_last_element),
      .csr_valid           (csr_valid & csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_shannon_bits    (rsp_shannon_bits),
      .rsp_linear_entropy  (rsp_linear_entropy),
      .rsp_renyi_entropy   (rsp_renyi_entropy),
      .rsp_tsallis_entropy (rsp_tsallis_entropy)
   );

endmodule

// ----- hdl/mea_checker.sv -----
// ----------------------------------------------------------------------------
// mea_checker
// port level checks for the entropy accumulator, bound to the top level
// ----------------------------------------------------------------------------
module mea_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               req_last_element,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [20:0]        rsp_shannon_bits,
   input logic [20:0]        rsp_linear_entropy,
   input logic signed [20:0] rsp_renyi_entropy,
   input logic signed [31:0] rsp_tsallis_entropy
);
   logic [1:0] pend_ff, pend_in;
   logic       last_beat, rsp_beat;

   assign last_beat = req_valid & ~req_stall & req_last_element;
   assign rsp_beat  = rsp_valid & ~rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (last_beat && !rsp_beat) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_beat && !last_beat) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tsallis_entropy)
                                 && $stable(rsp_renyi_entropy)
                                 && $stable(rsp_shannon_bits)
                                 && $stable(rsp_linear_entropy))
      else $error("stalled result beat changed");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on back to back cycles");

   a_rsp_has_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result beat without a vector end");

   a_rsp_only_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(pend_ff) != 2'd0 || $past(last_beat))
      else $error("result raised without a pending vector");

endmodule

bind multi_entropy_accumulator_unit mea_checker u_mea_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks multi_entropy_accumulator_unit against a bit-exact fixed-point
// predictor of the four entropies, over directed vectors, long vectors,
// random vectors under several idle and stall mixes and a long result hold
// ----------------------------------------------------------------------------
module tb;
   import mea_pkg::*;

   typedef struct {
      logic [20:0]        shannon;
      logic [20:0]        linear;
      logic signed [20:0] renyi;
      logic signed [31:0] tsallis;
   } entropy_set_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [16:0]        req_probability = '0;
   logic               req_last_element = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [20:0]        rsp_shannon_bits;
   logic [20:0]        rsp_linear_entropy;
   logic signed [20:0] rsp_renyi_entropy;
   logic signed [31:0] rsp_tsallis_entropy;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic               csr_index = 1'b0;
   logic [15:0]        csr_data = '0;

   entropy_set_type entropy_q[$];
   int           errors = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   int           hold_start = 0;
   int           hold_left = 0;

   // predictor state
   logic [15:0] order_q_cfg = ORDER_Q_RST;
   logic [15:0] skip_cfg = SKIP_RST;
   logic [31:0] shannon_acc = '0;
   logic [23:0] linear_acc = '0;
   logic [31:0] power_acc = '0;
   int          elem_cnt = 0;

   multi_entropy_accumulator_unit uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("multi_entropy_accumulator_unit verification failed");
      $finish;
   end

   function automatic logic [31:0] log2_fix(input logic [31:0] x);
      int          top;
      logic [63:0] y;
      logic [31:0] frac;
      top  = 0;
      frac = '0;
      if (x == 0) return '0;
      for (int i = 0; i < 32; i++) if (x[i]) top = i;
      if (top <= 30) y = {32'd0, x} << (30 - top);
      else y = {32'd0, x} >> (top - 30);
      for (int i = 15; i >= 0; i--) begin
         y = (y * y) >> 30;
         if (y >= (64'd1 << 31)) begin
            y       = y >> 1;
            frac[i] = 1'b1;
         end
      end
      return (32'(top) << 16) | frac;
   endfunction

   function automatic logic [63:0] int_root(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] b;
      x   = x_in;
      res = '0;
      b   = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x   = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] pow2_neg(input logic [31:0] e);
      logic [15:0] f;
      logic [63:0] r;
      logic [63:0] acc;
      int          n;
      n   = e >> 16;
      f   = e[15:0];
      r   = 64'd1 << 29;
      acc = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
         r = int_root(r << 30);
         if (f[16-k]) acc = (acc * r) >> 30;
      end
      if (n > 31) return '0;
      return 32'(acc >> (14 + n));
   endfunction

   function automatic longint over_one_minus_q(input longint num);
      logic [63:0] den;
      logic [63:0] mag;
      logic [63:0] quo;
      den = 64'd65536 - order_q_cfg;
      mag = (num < 0) ? -num : num;
      quo = (mag << 16) / den;
      return (num < 0) ? -longint'(quo) : longint'(quo);
   endfunction

   function automatic void add_probability(input logic [16:0] p);
      logic [31:0] d;
      logic [31:0] e;
      logic [63:0] p64;
      if (p == 0) begin
         if (order_q_cfg == 0) power_acc += 32'd65536;
         return;
      end
      p64 = p;
      d   = (32'd16 << 16) - log2_fix(32'(p));
      e   = 32'((64'(order_q_cfg) * d) >> 16);
      shannon_acc += 32'((p64 * d) >> 16);
      linear_acc  += 24'((p64 * (64'd65536 - p64)) >> 16);
      power_acc   += pow2_neg(e);
   endfunction

   function automatic void predict_entropy(input logic [16:0] p_in, input logic last);
      logic [16:0]  p;
      longint       ren;
      longint       ts;
      longint       v;
      logic [63:0]  mag;
      logic [63:0]  lnm;
      entropy_set_type s;
      p = (p_in > ONE_Q16) ? ONE_Q16 : p_in;
      if (elem_cnt < MAX_ELEMENTS) begin
         elem_cnt++;
         if (p >= skip_cfg) add_probability(p);
      end
      if (!last) return;
      if (power_acc <= skip_cfg) begin
         ren = -65536;
      end else begin
         v   = longint'(log2_fix(power_acc)) - (longint'(16) << 16);
         mag = (v < 0) ? -v : v;
         lnm = (mag * 64'(LN2_Q30)) >> 30;
         ren = over_one_minus_q((v < 0) ? -longint'(lnm) : longint'(lnm));
         if (ren > 1048575) ren = 1048575;
         if (ren < -1048576) ren = -1048576;
      end
      ts = over_one_minus_q(longint'(power_acc) - 65536);
      if (ts > 64'sd2147483647) ts = 64'sd2147483647;
      if (ts < -64'sd2147483648) ts = -64'sd2147483648;
      s.shannon = (shannon_acc > U21_MAX) ? U21_MAX : shannon_acc[20:0];
      s.linear  = (linear_acc > U21_MAX) ? U21_MAX : linear_acc[20:0];
      s.renyi   = ren[20:0];
      s.tsallis = ts[31:0];
      entropy_q.push_back(s);
      shannon_acc = '0;
      linear_acc  = '0;
      power_acc   = '0;
      elem_cnt    = 0;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // receiver: random stall plus an occasional long hold
   always @(posedge clock) begin
      if (hold_start > 0) begin
         hold_left  = hold_start;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      entropy_set_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (entropy_q.size() == 0) begin
            report("unexpected beat", 32'(rsp_shannon_bits), 32'd0);
         end else begin
            w = entropy_q.pop_front();
            if (rsp_shannon_bits !== w.shannon)
               report("shannon", 32'(rsp_shannon_bits), 32'(w.shannon));
            if (rsp_linear_entropy !== w.linear)
               report("linear", 32'(rsp_linear_entropy), 32'(w.linear));
            if (rsp_renyi_entropy !== w.renyi)
               report("renyi", 32'(rsp_renyi_entropy), 32'(w.renyi));
            if (rsp_tsallis_entropy !== w.tsallis)
               report("tsallis", rsp_tsallis_entropy, w.tsallis);
         end
      end
   end

   task automatic send_beat(input logic [16:0] p, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_probability  <= p;
      req_last_element <= last;
      do @(posedge clock); while (req_stall);
      predict_entropy(p, last);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (entropy_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == CSR_ORDER_Q) order_q_cfg = data;
      else skip_cfg = data;
   endtask

   function automatic logic [16:0] rand_probability();
      int r;
      r = $urandom_range(99);
      if (r < 75) return 17'($urandom_range(65536));
      if (r < 85) return 17'($urandom_range(16));
      if (r < 92) return 17'($urandom_range(65536, 65500));
      return 17'($urandom);
   endfunction

   task automatic send_vector(input int len);
      for (int i = 0; i < len; i++) send_beat(rand_probability(), i == len - 1);
   endtask

   task automatic test_directed();
      write_csr(CSR_ORDER_Q, ORDER_Q_RST);
      write_csr(CSR_SKIP, SKIP_RST);
      send_beat(17'd0, 1'b0);
      send_beat(17'd1, 1'b0);
      send_beat(17'h10000, 1'b0);
      send_beat(17'h1FFFF, 1'b1);
      send_beat(17'h10000, 1'b1);
      send_beat(17'd0, 1'b1);
      drain();
      write_csr(CSR_ORDER_Q, 16'd0);
      write_csr(CSR_SKIP, 16'd0);
      send_beat(17'd0, 1'b0);
      send_beat(17'd32768, 1'b0);
      send_beat(17'd32768, 1'b1);
      send_beat(17'd0, 1'b1);
      drain();
      write_csr(CSR_ORDER_Q, 16'hFFFF);
      write_csr(CSR_SKIP, 16'hFFFF);
      send_beat(17'hFFFF, 1'b0);
      send_beat(17'h10000, 1'b0);
      send_beat(17'd3, 1'b1);
      send_beat(17'h0AAAA, 1'b0);
      send_beat(17'h15555, 1'b1);
      drain();
   endtask

   task automatic test_long_vector();
      write_csr(CSR_ORDER_Q, 16'd16384);
      write_csr(CSR_SKIP, 16'd1);
      for (int i = 0; i < 36; i++) send_beat(17'd2048, i == 35);
      drain();
   endtask

   task automatic test_random_phase(input int idle, input int stall, input int items);
      int sent;
      int r;
      r = $urandom_range(3);
      write_csr(CSR_ORDER_Q, (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom));
      r = $urandom_range(5);
      write_csr(CSR_SKIP, (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom) : 16'($urandom_range(64)));
      send_idle_pct = idle;
      stall_pct     = stall;
      sent          = 0;
      while (sent < items) begin
         r = ($urandom_range(9) == 0) ? $urandom_range(40, 30) : $urandom_range(12, 1);
         send_vector(r);
         sent += r;
      end
      drain();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_start    = 800;
      for (int i = 0; i < 30; i++) send_vector($urandom_range(2, 1));
      drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_vector();
      test_random_phase(0, 0, 400);
      test_random_phase(87, 0, 400);
      test_random_phase(0, 87, 400);
      test_random_phase(23, 23, 400);
      test_backpressure();
      if (errors == 0) begin
         $display("multi_entropy_accumulator_unit verification clean");
      end else begin
         $display("multi_entropy_accumulator_unit verification failed");
      end
      $finish;
   end

endmodule
